// ----- src/sipc_pkg.sv -----
// Shared types and constants for the scratch image pool cache.
package sipc_pkg;

  localparam int unsigned KeyW = 56;
  localparam int unsigned HandleW = 16;
  localparam int unsigned EntryW = KeyW + HandleW;
  localparam logic [15:0] DiscardAgeReset = 16'd100;
  localparam logic [3:0] FramesInFlightReset = 4'd2;

  typedef enum logic [1:0] {
    CmdAcquire = 2'd0,
    CmdFrameStart = 2'd1,
    CmdFrameEnd = 2'd2,
    CmdClear = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StReused = 3'd0,
    StCreated = 3'd1,
    StCreateFail = 3'd2,
    StStoreFull = 3'd3,
    StFrameDone = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    RegDiscardAge = 1'd0,
    RegFramesInFlight = 1'd1
  } reg_e;

  typedef enum logic [13:0] {
    SIdle = 14'b00000000000001,
    SAcqRd = 14'b00000000000010,
    SAcqChk = 14'b00000000000100,
    SShRd = 14'b00000000001000,
    SShWr = 14'b00000000010000,
    SDropRd = 14'b00000000100000,
    SDropChk = 14'b00000001000000,
    SRetRd = 14'b00000010000000,
    SRetChk = 14'b00000100000000,
    SPosRd = 14'b00001000000000,
    SPosChk = 14'b00010000000000,
    SInsWr = 14'b00100000000000,
    SOut = 14'b01000000000000,
    SInsRd = 14'b10000000000000
  } state_e;

  function automatic logic [3:0] ceil_log2(input logic [14:0] v);
    logic [3:0] k;
    k = 4'd15;
    for (int i = 14; i >= 0; i--) begin
      if ({17'd0, v} <= (32'd1 << i)) k = 4'(i);
    end
    return k;
  endfunction

  function automatic logic [5:0] key_vol(input logic [KeyW-1:0] k);
    return {2'b0, k[15:12]} + {2'b0, k[19:16]} + {2'b0, k[23:20]};
  endfunction

  function automatic logic key_less(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    if (a[3:0] != b[3:0]) return a[3:0] < b[3:0];
    if (a[11:4] != b[11:4]) return a[11:4] < b[11:4];
    return key_vol(a) < key_vol(b);
  endfunction

endpackage

// ----- src/scratch_image_pool_cache_core.sv -----
// Top level of the scratch image pool cache.
// Every command takes one beat and returns one beat. The free table lies in a
// single-port memory with registered read and the in-flight FIFO in a memory
// with a separate write port and a registered read of its head, so one
// free-table entry is read or written per cycle: an acquire scans the free
// table from its start, reading and then checking each entry, and on a hit
// shifts the tail down by reading and writing each entry; a frame end makes a
// compaction pass over the free table and then, for each returned entry, a
// search for its place and a shift of the tail. Frame start, clear and an
// acquire refused for a full in-flight FIFO put their result out in the cycle
// after the command is taken. The next command is taken in the cycle after the
// result beat has been accepted.
module scratch_image_pool_cache_core #(
  parameter int unsigned FREE_DEPTH = 32,
  parameter int unsigned BUSY_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  image_kind_i,
  input  logic [7:0]  pixel_format_i,
  input  logic [14:0] width_req_i,
  input  logic [14:0] height_req_i,
  input  logic [14:0] depth_req_i,
  input  logic [31:0] frame_number_i,
  input  logic        create_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] image_handle_o,
  output logic [5:0]  dropped_count_o,
  output logic [5:0]  returned_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sipc_pkg::*;

  localparam int unsigned FAW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned BAW = (BUSY_DEPTH > 1) ? $clog2(BUSY_DEPTH) : 1;
  localparam int unsigned FCW = $clog2(FREE_DEPTH + 1);
  localparam int unsigned BCW = $clog2(BUSY_DEPTH + 1);

  logic [EntryW-1:0] free_mem [FREE_DEPTH];
  logic [EntryW-1:0] busy_mem [BUSY_DEPTH];

  state_e state_q, state_d;
  logic [15:0] discard_age_q;
  logic [3:0] fif_q;
  logic [FCW-1:0] free_count_q, free_count_d;
  logic [BAW-1:0] busy_head_q, busy_head_d;
  logic [BCW-1:0] busy_count_q, busy_count_d;
  logic [31:0] cur_frame_q, cur_frame_d;
  logic [15:0] next_handle_q, next_handle_d;
  logic [FCW-1:0] idx_q, idx_d;
  logic [FCW-1:0] wi_q, wi_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [EntryW-1:0] ent_q, ent_d;
  logic [31:0] frame_q, frame_d;
  logic create_q, create_d;
  logic [5:0] drop_q, drop_d, ret_q, ret_d;
  logic [2:0] st_q, st_d;
  logic [15:0] hd_q, hd_d;
  logic is_end_q, is_end_d;

  logic f_we, b_we;
  logic [FAW-1:0] f_addr;
  logic [BAW-1:0] b_waddr;
  logic [EntryW-1:0] f_wdata, b_wdata, f_rdata, b_rdata;

  always_ff @(posedge clk_i) begin
    if (f_we) free_mem[f_addr] <= f_wdata;
    f_rdata <= free_mem[f_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) busy_mem[b_waddr] <= b_wdata;
    b_rdata <= busy_mem[busy_head_q];
  end

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegDiscardAge: prdata = {16'd0, discard_age_q};
      RegFramesInFlight: prdata = {28'd0, fif_q};
      default: prdata = '0;
    endcase
  end

  logic in_acc, out_acc;
  assign in_stall_o = (state_q != SIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == SOut);
  assign out_acc = out_valid_o && !out_stall_i;
  assign status_o = st_q;
  assign image_handle_o = hd_q;
  assign dropped_count_o = drop_q;
  assign returned_count_o = ret_q;

  logic [KeyW-1:0] e_key;
  logic [HandleW-1:0] e_h;
  logic [BAW-1:0] b_tail;
  logic [31:0] b_sum;
  assign e_key = f_rdata[KeyW-1:0];
  assign e_h = f_rdata[EntryW-1:KeyW];

  logic signed [32:0] bage;
  assign bage = $signed({1'b0, frame_q}) - $signed({1'b0, b_rdata[55:24]});
  logic signed [32:0] fage;
  assign fage = $signed({1'b0, frame_q}) - $signed({1'b0, e_key[55:24]});

  always_comb begin
    b_sum = 32'(busy_head_q) + 32'(busy_count_q);
    b_tail = (b_sum >= BUSY_DEPTH) ? BAW'(b_sum - BUSY_DEPTH) : BAW'(b_sum);
  end

  function automatic logic [5:0] sat_inc(input logic [5:0] v);
    return (v == 6'd63) ? v : v + 6'd1;
  endfunction

  always_comb begin
    state_d = state_q;
    free_count_d = free_count_q;
    busy_head_d = busy_head_q;
    busy_count_d = busy_count_q;
    cur_frame_d = cur_frame_q;
    next_handle_d = next_handle_q;
    idx_d = idx_q;
    wi_d = wi_q;
    key_d = key_q;
    ent_d = ent_q;
    frame_d = frame_q;
    create_d = create_q;
    drop_d = drop_q;
    ret_d = ret_q;
    st_d = st_q;
    hd_d = hd_q;
    is_end_d = is_end_q;
    f_we = 1'b0;
    f_addr = FAW'(idx_q);
    f_wdata = ent_q;
    b_we = 1'b0;
    b_waddr = b_tail;
    b_wdata = {next_handle_q, key_q};
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          st_d = StFrameDone;
          hd_d = '0;
          drop_d = '0;
          ret_d = '0;
          frame_d = frame_number_i;
          create_d = create_ok_i;
          idx_d = '0;
          key_d = {cur_frame_q, ceil_log2(depth_req_i), ceil_log2(height_req_i),
                   ceil_log2(width_req_i), pixel_format_i, image_kind_i};
          f_addr = '0;
          case (command_i)
            CmdAcquire: begin
              if (32'(busy_count_q) >= BUSY_DEPTH) begin
                st_d = StStoreFull;
                state_d = SOut;
              end else begin
                state_d = SAcqRd;
              end
            end
            CmdFrameStart: begin
              cur_frame_d = frame_number_i;
              state_d = SOut;
            end
            CmdFrameEnd: begin
              wi_d = '0;
              state_d = SDropRd;
            end
            default: begin
              free_count_d = '0;
              busy_head_d = '0;
              busy_count_d = '0;
              state_d = SOut;
            end
          endcase
        end
      end
      SAcqRd: begin
        if (idx_q >= free_count_q) begin
          if (create_q) begin
            b_we = 1'b1;
            busy_count_d = busy_count_q + 1'b1;
            hd_d = next_handle_q;
            next_handle_d = next_handle_q + 16'd1;
            st_d = StCreated;
          end else begin
            st_d = StCreateFail;
          end
          state_d = SOut;
        end else begin
          state_d = SAcqChk;
        end
      end
      SAcqChk: begin
        if (key_less(e_key, key_q)) begin
          idx_d = idx_q + 1'b1;
          f_addr = FAW'(idx_q + 1'b1);
          state_d = SAcqRd;
        end else if (e_key[11:0] != key_q[11:0]) begin
          idx_d = free_count_q;
          state_d = SAcqRd;
        end else if (e_key[15:12] >= key_q[15:12] && e_key[19:16] >= key_q[19:16]
                     && e_key[23:20] >= key_q[23:20]) begin
          b_we = 1'b1;
          b_wdata = {e_h, key_q[55:24], e_key[23:0]};
          busy_count_d = busy_count_q + 1'b1;
          hd_d = e_h;
          st_d = StReused;
          is_end_d = 1'b0;
          idx_d = idx_q + 1'b1;
          f_addr = FAW'(idx_q + 1'b1);
          state_d = SShRd;
        end else begin
          idx_d = idx_q + 1'b1;
          f_addr = FAW'(idx_q + 1'b1);
          state_d = SAcqRd;
        end
      end
      SShRd: begin
        if (idx_q >= free_count_q) begin
          free_count_d = free_count_q - 1'b1;
          state_d = is_end_q ? SRetRd : SOut;
        end else begin
          state_d = SShWr;
        end
      end
      SShWr: begin
        f_we = 1'b1;
        f_addr = FAW'(idx_q - 1'b1);
        f_wdata = f_rdata;
        idx_d = idx_q + 1'b1;
        state_d = SShRd;
      end
      SDropRd: begin
        f_addr = FAW'(idx_q);
        if (idx_q >= free_count_q) begin
          free_count_d = wi_q;
          state_d = SRetRd;
        end else begin
          state_d = SDropChk;
        end
      end
      SDropChk: begin
        if (fage >= $signed({17'd0, discard_age_q})) begin
          drop_d = sat_inc(drop_q);
        end else begin
          f_we = 1'b1;
          f_addr = FAW'(wi_q);
          f_wdata = f_rdata;
          wi_d = wi_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        state_d = SDropRd;
      end
      SRetRd: begin
        state_d = SRetChk;
      end
      SRetChk: begin
        if (busy_count_q == '0 || bage < $signed({29'd0, fif_q})
            || 32'(free_count_q) >= FREE_DEPTH) begin
          state_d = SOut;
        end else begin
          ent_d = b_rdata;
          idx_d = '0;
          f_addr = '0;
          state_d = SPosRd;
        end
      end
      SPosRd: begin
        if (idx_q >= free_count_q) begin
          wi_d = free_count_q;
          state_d = SInsWr;
        end else begin
          state_d = SPosChk;
        end
      end
      SPosChk: begin
        if (key_less(e_key, ent_q[KeyW-1:0])) begin
          idx_d = idx_q + 1'b1;
          f_addr = FAW'(idx_q + 1'b1);
          state_d = SPosRd;
        end else begin
          f_addr = FAW'(free_count_q - 1'b1);
          wi_d = free_count_q;
          state_d = SInsWr;
        end
      end
      SInsRd: begin
        f_addr = FAW'(wi_q - 1'b1);
        state_d = SInsWr;
      end
      SInsWr: begin
        f_we = 1'b1;
        f_addr = FAW'(wi_q);
        if (wi_q == idx_q) begin
          f_wdata = ent_q;
          free_count_d = free_count_q + 1'b1;
          busy_head_d = (32'(busy_head_q) == BUSY_DEPTH - 1) ? '0 : busy_head_q + 1'b1;
          busy_count_d = busy_count_q - 1'b1;
          ret_d = sat_inc(ret_q);
          state_d = SRetRd;
        end else begin
          f_wdata = f_rdata;
          wi_d = wi_q - 1'b1;
          state_d = SInsRd;
        end
      end
      SOut: begin
        if (out_acc) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      discard_age_q <= DiscardAgeReset;
      fif_q <= FramesInFlightReset;
      free_count_q <= '0;
      busy_head_q <= '0;
      busy_count_q <= '0;
      cur_frame_q <= '0;
      next_handle_q <= '0;
      is_end_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_count_q <= free_count_d;
      busy_head_q <= busy_head_d;
      busy_count_q <= busy_count_d;
      cur_frame_q <= cur_frame_d;
      next_handle_q <= next_handle_d;
      is_end_q <= is_end_d;
      if (cfg_wr && paddr[1:0] == 2'd0) begin
        if (paddr[2] == RegDiscardAge) discard_age_q <= pwdata[15:0];
        else fif_q <= pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wi_q <= wi_d;
    key_q <= key_d;
    ent_q <= ent_d;
    frame_q <= frame_d;
    create_q <= create_d;
    drop_q <= drop_d;
    ret_q <= ret_d;
    st_q <= st_d;
    hd_q <= hd_d;
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_count_q) <= FREE_DEPTH) else $error("free count overflow");
  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(busy_count_q) <= BUSY_DEPTH) else $error("busy count overflow");
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !out_valid_o) else $error("result repeated");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

endmodule

// ----- bench/scratch_image_pool_cache_core_test.sv -----
// Testbench for the scratch image pool cache: directed and random command beats checked against a pool model.
`timescale 1ns / 1ps
module scratch_image_pool_cache_core_test;
  import sipc_pkg::*;

  localparam int Depth = 32;
  localparam int HoldCycles = 800;

  typedef struct {
    cmd_e cmd;
    logic [3:0] kind;
    logic [7:0] fmt;
    logic [14:0] w, h, d;
    logic [31:0] frame;
    logic ok;
  } pool_cmd_t;

  typedef struct {
    status_e st;
    logic [15:0] handle;
    logic [5:0] dropped;
    logic [5:0] returned;
  } pool_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic [3:0] image_kind_i = '0;
  logic [7:0] pixel_format_i = '0;
  logic [14:0] width_req_i = '0, height_req_i = '0, depth_req_i = '0;
  logic [31:0] frame_number_i = '0;
  logic create_ok_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [15:0] image_handle_o;
  logic [5:0] dropped_count_o, returned_count_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scratch_image_pool_cache_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // pool model state
  logic [KeyW-1:0] free_key[Depth];
  logic [15:0] free_hdl[Depth];
  int free_cnt;
  logic [KeyW-1:0] busy_key[Depth];
  logic [15:0] busy_hdl[Depth];
  int busy_head, busy_cnt;
  logic [31:0] cur_frame;
  logic [15:0] next_hdl;
  logic [15:0] discard_age;
  logic [3:0] in_flight;

  pool_cmd_t pending_q[$];
  pool_res_t expected_q[$];
  int errs = 0;

  function automatic logic [3:0] extent_log2(logic [14:0] v);
    int k;
    k = 0;
    while (k < 15 && (32'd1 << k) < {17'd0, v}) k++;
    return 4'(k);
  endfunction

  function automatic int vol_of(logic [KeyW-1:0] k);
    return int'(k[15:12]) + int'(k[19:16]) + int'(k[23:20]);
  endfunction

  function automatic bit sorts_first(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    if (a[3:0] != b[3:0]) return a[3:0] < b[3:0];
    if (a[11:4] != b[11:4]) return a[11:4] < b[11:4];
    return vol_of(a) < vol_of(b);
  endfunction

  function automatic int first_slot(logic [KeyW-1:0] k);
    int i;
    i = 0;
    while (i < free_cnt && sorts_first(free_key[i], k)) i++;
    return i;
  endfunction

  function automatic void free_take(int i);
    for (int j = i; j + 1 < free_cnt; j++) begin
      free_key[j] = free_key[j+1];
      free_hdl[j] = free_hdl[j+1];
    end
    free_cnt--;
  endfunction

  function automatic void busy_put(logic [KeyW-1:0] k, logic [15:0] hd);
    int slot;
    slot = (busy_head + busy_cnt) % Depth;
    busy_key[slot] = k;
    busy_hdl[slot] = hd;
    busy_cnt++;
  endfunction

  function automatic longint age_at(logic [31:0] now, logic [KeyW-1:0] k);
    return longint'({32'd0, now}) - longint'({32'd0, k[55:24]});
  endfunction

  function automatic pool_res_t pool_apply(pool_cmd_t c);
    pool_res_t r;
    logic [KeyW-1:0] key, e;
    bit hit;
    int i, pos, hb, dr, rt;
    r = '{StFrameDone, 16'd0, 6'd0, 6'd0};
    dr = 0;
    rt = 0;
    case (c.cmd)
      CmdAcquire: begin
        key = {cur_frame, extent_log2(c.d), extent_log2(c.h), extent_log2(c.w), c.fmt, c.kind};
        if (busy_cnt >= Depth) begin
          r.st = StStoreFull;
        end else begin
          hit = 0;
          for (i = first_slot(key); i < free_cnt; i++) begin
            e = free_key[i];
            if (e[11:0] != key[11:0]) break;
            if (e[15:12] >= key[15:12] && e[19:16] >= key[19:16] && e[23:20] >= key[23:20]) begin
              r.st = StReused;
              r.handle = free_hdl[i];
              free_take(i);
              busy_put({cur_frame, e[23:0]}, r.handle);
              hit = 1;
              break;
            end
          end
          if (!hit) begin
            if (c.ok) begin
              r.st = StCreated;
              r.handle = next_hdl;
              busy_put(key, next_hdl);
              next_hdl++;
            end else begin
              r.st = StCreateFail;
            end
          end
        end
      end
      CmdFrameStart: cur_frame = c.frame;
      CmdFrameEnd: begin
        i = 0;
        while (i < free_cnt) begin
          if (age_at(c.frame, free_key[i]) >= longint'(discard_age)) begin
            free_take(i);
            dr++;
          end else begin
            i++;
          end
        end
        while (busy_cnt > 0) begin
          hb = busy_head;
          if (age_at(c.frame, busy_key[hb]) < longint'(in_flight)) break;
          if (free_cnt >= Depth) break;
          pos = first_slot(busy_key[hb]);
          for (int j = free_cnt; j > pos; j--) begin
            free_key[j] = free_key[j-1];
            free_hdl[j] = free_hdl[j-1];
          end
          free_key[pos] = busy_key[hb];
          free_hdl[pos] = busy_hdl[hb];
          free_cnt++;
          busy_head = (hb + 1) % Depth;
          busy_cnt--;
          rt++;
        end
        r.dropped = 6'(dr > 63 ? 63 : dr);
        r.returned = 6'(rt > 63 ? 63 : rt);
      end
      default: begin
        free_cnt = 0;
        busy_head = 0;
        busy_cnt = 0;
      end
    endcase
    return r;
  endfunction

  // sender: bursts with random gaps
  pool_cmd_t drv_item;
  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_q.push_back(pool_apply(drv_item));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_item = pending_q.pop_front();
          command_i <= drv_item.cmd;
          image_kind_i <= drv_item.kind;
          pixel_format_i <= drv_item.fmt;
          width_req_i <= drv_item.w;
          height_req_i <= drv_item.h;
          depth_req_i <= drv_item.d;
          frame_number_i <= drv_item.frame;
          create_ok_i <= drv_item.ok;
          in_valid_i <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long hold-off, counted here
  int hold_seq = 0, hold_seen = 0, hold_cnt = 0;

  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= HoldCycles;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver: check beats, stall on a pattern of its own
  int stall_mode = 0, mode_left = 0;
  pool_res_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result beat: status %0d handle %0d", status_o,
                                   image_handle_o);
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.st || image_handle_o !== want.handle ||
              dropped_count_o !== want.dropped || returned_count_o !== want.returned) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected st %0d hd %0d dr %0d rt %0d, got st %0d hd %0d dr %0d rt %0d",
                       want.st, want.handle, want.dropped, want.returned, status_o,
                       image_handle_o, dropped_count_o, returned_count_o);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      out_stall_i <= (hold_cnt > 0) ||
                     (stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                     (stall_mode == 2 && $urandom_range(0, 3) != 0);
    end
  end

  function automatic pool_cmd_t mk(cmd_e c, logic [3:0] k, logic [7:0] f, logic [14:0] w,
                                   logic [14:0] h, logic [14:0] d, logic [31:0] fr, logic ok);
    pool_cmd_t p;
    p = '{c, k, f, w, h, d, fr, ok};
    return p;
  endfunction

  function automatic logic [14:0] rnd_extent();
    if ($urandom_range(0, 3) != 0) return 15'($urandom_range(1, 64));
    return 15'($urandom_range(0, 32767));
  endfunction

  function automatic pool_cmd_t rnd_acquire();
    return mk(CmdAcquire, 4'($urandom_range(0, 1)), 8'($urandom_range(0, 2)), rnd_extent(),
              rnd_extent(), rnd_extent(), 32'd0, $urandom_range(0, 7) != 0);
  endfunction

  function automatic pool_cmd_t rnd_noise();
    return mk(cmd_e'($urandom_range(0, 3)), 4'($urandom), 8'($urandom), 15'($urandom),
              15'($urandom), 15'($urandom), $urandom, 1'($urandom));
  endfunction

  task automatic reg_write(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    wait (pending_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] age, logic [3:0] fl);
    settle();
    reg_write(RegDiscardAge, {16'd0, age});
    reg_write(RegFramesInFlight, {28'd0, fl});
    discard_age = age;
    in_flight = fl;
  endtask

  task automatic add_random(int n, int max_acq);
    logic [31:0] fr;
    int got, na;
    got = 0;
    fr = cur_frame;
    while (got < n) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_q.push_back(rnd_noise());
        got++;
      end else begin
        fr = ($urandom_range(0, 15) == 0) ? $urandom : fr + 32'd1;
        pending_q.push_back(mk(CmdFrameStart, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, fr, 1'b0));
        na = $urandom_range(0, max_acq);
        for (int i = 0; i < na; i++) pending_q.push_back(rnd_acquire());
        if ($urandom_range(0, 19) == 0) fr = fr - 32'd1;
        pending_q.push_back(mk(CmdFrameEnd, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, fr, 1'b0));
        if ($urandom_range(0, 39) == 0)
          pending_q.push_back(mk(CmdClear, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'd0, 1'b0));
        got += na + 2;
      end
    end
  endtask

  initial begin
    free_cnt = 0;
    busy_head = 0;
    busy_cnt = 0;
    cur_frame = '0;
    next_hdl = '0;
    discard_age = DiscardAgeReset;
    in_flight = FramesInFlightReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_q.push_back(mk(CmdAcquire, 4'd0, 8'd0, 15'd0, 15'd0, 15'd0, 32'd0, 1'b1));
    pending_q.push_back(mk(CmdAcquire, 4'd15, 8'd255, 15'd16384, 15'd16384, 15'd16384, 32'd0, 1'b1));
    pending_q.push_back(mk(CmdAcquire, 4'd15, 8'd255, 15'd32767, 15'd16385, 15'd1, 32'd0, 1'b1));
    pending_q.push_back(mk(CmdAcquire, 4'd3, 8'd7, 15'd5, 15'd9, 15'd2, 32'd0, 1'b0));
    pending_q.push_back(mk(CmdAcquire, 4'd3, 8'd7, 15'd4, 15'd8, 15'd2, 32'd0, 1'b1));
    pending_q.push_back(mk(CmdFrameStart, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'd2, 1'b0));
    pending_q.push_back(mk(CmdFrameEnd, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'd2, 1'b0));
    pending_q.push_back(mk(CmdAcquire, 4'd3, 8'd7, 15'd3, 15'd7, 15'd1, 32'd0, 1'b0));
    pending_q.push_back(mk(CmdAcquire, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'd0, 1'b0));
    pending_q.push_back(mk(CmdAcquire, 4'd15, 8'd255, 15'd32767, 15'd32767, 15'd32767, 32'd0, 1'b0));
    pending_q.push_back(mk(CmdFrameStart, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'hFFFF_FFFF, 1'b0));
    pending_q.push_back(mk(CmdFrameEnd, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'hFFFF_FFFF, 1'b0));
    pending_q.push_back(mk(CmdAcquire, 4'd15, 8'd255, 15'd1, 15'd1, 15'd1, 32'd0, 1'b1));
    pending_q.push_back(mk(CmdClear, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'd0, 1'b0));
    pending_q.push_back(mk(CmdFrameEnd, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'd0, 1'b0));
    for (int i = 0; i < 34; i++)
      pending_q.push_back(mk(CmdAcquire, 4'd1, 8'd1, 15'd2, 15'd2, 15'd2, 32'd0, 1'b1));
    pending_q.push_back(mk(CmdFrameEnd, 4'd0, 8'd0, 15'd1, 15'd1, 15'd1, 32'hFFFF_FFFF, 1'b0));
    add_random(250, 8);
    set_regs(16'd1, 4'd1);
    add_random(300, 6);
    @(posedge clk_i);
    hold_seq <= hold_seq + 1;
    set_regs(16'hFFFF, 4'd8);
    add_random(300, 20);
    set_regs(16'd0, 4'd0);
    add_random(250, 8);
    set_regs(16'd3, 4'd4);
    add_random(300, 12);
    set_regs(16'd12, 4'hF);
    add_random(300, 10);
    settle();
    repeat (50) @(posedge clk_i);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
